// File: rtl/shifted_bitmap_row_blitter_macros.svh
// ----------------------------------------------------------------------------
// Bitmap row blitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHIFTED_BITMAP_ROW_BLITTER_MACROS_SVH
`define SHIFTED_BITMAP_ROW_BLITTER_MACROS_SVH

// same-cycle implication
`define SBRB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sbrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap row blitter package
// Payload types, field widths and controller/datapath command types.
// ----------------------------------------------------------------------------
package sbrb_pkg;

	localparam int WORD_W         = 16;
	localparam int SHIFT_W        = 4;
	localparam int POS_X_W        = 10;
	localparam int POS_Y_W        = 9;
	localparam int ROW_CNT_W      = 9;
	localparam int RADDR_W        = 14;
	localparam int LINE_WORDS_DEF = 40;
	localparam int SCREEN_LINES_DEF = 400;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic                 operation;
		logic                 replace_mode;
		logic [POS_X_W-1:0]   pos_x;
		logic [POS_Y_W-1:0]   pos_y;
		logic [WORD_W-1:0]    row_bits;
		logic                 last_row;
		logic [RADDR_W-1:0]   read_address;
	} blit_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic              dropped;
	} blit_rsp_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_A0,
		RD_A1,
		RD_REQ
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLR,
		WR_A0,
		WR_A1
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    load_rsp;
	} sbrb_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic req_read;
	} sbrb_sts_t;

endpackage

// File: rtl/sbrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap row blitter controller
// Sequences the clearing pass, the word read-modify-write steps, the
// framebuffer read and the response handoff.
// ----------------------------------------------------------------------------
`include "shifted_bitmap_row_blitter_macros.svh"

module sbrb_ctrl
	import sbrb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  sbrb_sts_t sts,
	output sbrb_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_WR1,
		ST_RDR,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   rsp_valid_q;
	logic   slot_free;

	assign req_ready = ready_q;
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd = '{load: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, load_rsp: 1'b0};
		unique case (state_q)
			ST_CLEAR: cmd.wr_sel = WR_CLR;
			ST_IDLE:  cmd.load = req_valid && ready_q;
			ST_RD0:   cmd.rd_sel = RD_A0;
			ST_RD1: begin
				cmd.wr_sel = WR_A0;
				cmd.rd_sel = RD_A1;
			end
			ST_WR1:   cmd.wr_sel = WR_A1;
			ST_RDR:   cmd.rd_sel = RD_REQ;
			ST_FIN:   cmd.load_rsp = slot_free;
			default:  cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ready_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.load) begin
						ready_q <= 1'b0;
						state_q <= sts.req_read ? ST_RDR : ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_WR1;
				ST_WR1: state_q <= ST_FIN;
				ST_RDR: state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	`SBRB_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready, "ready held after request")
	`SBRB_ASSERT_NOW(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q) == ST_FIN, "response raised outside finish")
	`SBRB_ASSERT_NOW(a_no_ready_in_clear, state_q == ST_CLEAR, !req_ready, "request taken during clear")

endmodule

// File: rtl/sbrb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap row blitter datapath
// Address and shift computation, framebuffer memory, row counter and
// response register.
// ----------------------------------------------------------------------------
`include "shifted_bitmap_row_blitter_macros.svh"

module sbrb_dpath
	import sbrb_pkg::*;
#(
	parameter int LINE_WORDS   = LINE_WORDS_DEF,
	parameter int SCREEN_LINES = SCREEN_LINES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  blit_req_t req,
	input  sbrb_cmd_t cmd,
	output sbrb_sts_t sts,
	output blit_rsp_t rsp
);

	localparam int MEM_WORDS = LINE_WORDS * SCREEN_LINES;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int CW        = $clog2(1023 * LINE_WORDS + 64 + MEM_WORDS);
	localparam int CMP_W     = (CW > RADDR_W) ? CW : RADDR_W;
	localparam logic [CMP_W-1:0]  MEM_LIMIT    = CMP_W'(MEM_WORDS);
	localparam logic [CMP_W-1:0]  LINE_WORDS_C = CMP_W'(LINE_WORDS);
	localparam logic [MEM_AW-1:0] CLR_LAST     = MEM_AW'(MEM_WORDS - 1);
	localparam logic [MEM_AW:0]   MEM_LIMIT_W  = (MEM_AW + 1)'(MEM_WORDS);

	logic [WORD_W-1:0] mem [MEM_WORDS];

	logic [POS_Y_W:0]      line_sum;
	logic [CMP_W-1:0]      addr_calc;
	logic [2*WORD_W-1:0]   spill_wide;
	logic [ROW_CNT_W-1:0]  row_cnt_q;
	logic [MEM_AW-1:0]     clr_cnt_q;

	logic                  op_q;
	logic                  replace_q;
	logic [CMP_W-1:0]      addr0_q;
	logic [WORD_W-1:0]     head_q;
	logic [WORD_W-1:0]     spill_q;
	logic [RADDR_W-1:0]    raddr_q;
	logic [WORD_W-1:0]     rdata_q;
	blit_rsp_t             rsp_q;

	logic [CMP_W-1:0]      addr1;
	logic [CMP_W-1:0]      raddr_ext;
	logic                  ok0;
	logic                  ok1;
	logic                  rd_ok;

	logic                  mem_we;
	logic [MEM_AW-1:0]     mem_waddr;
	logic [WORD_W-1:0]     mem_wdata;
	logic                  mem_re;
	logic [MEM_AW-1:0]     mem_raddr;

	assign line_sum   = (POS_Y_W + 1)'(req.pos_y) + (POS_Y_W + 1)'(row_cnt_q);
	assign addr_calc  = CMP_W'(line_sum) * LINE_WORDS_C
		+ CMP_W'(req.pos_x[POS_X_W-1:SHIFT_W]);
	assign spill_wide = {req.row_bits, WORD_W'(0)} >> req.pos_x[SHIFT_W-1:0];

	assign addr1     = addr0_q + CMP_W'(1);
	assign raddr_ext = CMP_W'(raddr_q);
	assign ok0       = addr0_q < MEM_LIMIT;
	assign ok1       = addr1 < MEM_LIMIT;
	assign rd_ok     = raddr_ext < MEM_LIMIT;

	assign sts.clr_last = clr_cnt_q == CLR_LAST;
	assign sts.req_read = req.operation == OP_READ;
	assign rsp          = rsp_q;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (cmd.rd_sel)
			RD_NONE: mem_re = 1'b0;
			RD_A0: begin
				mem_re    = ok0;
				mem_raddr = addr0_q[MEM_AW-1:0];
			end
			RD_A1: begin
				mem_re    = ok1;
				mem_raddr = addr1[MEM_AW-1:0];
			end
			RD_REQ: begin
				mem_re    = rd_ok;
				mem_raddr = raddr_ext[MEM_AW-1:0];
			end
			default: mem_re = 1'b0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		unique case (cmd.wr_sel)
			WR_NONE: mem_we = 1'b0;
			WR_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
			end
			WR_A0: begin
				mem_we    = ok0;
				mem_waddr = addr0_q[MEM_AW-1:0];
				mem_wdata = replace_q ? head_q : (rdata_q | head_q);
			end
			WR_A1: begin
				mem_we    = ok1;
				mem_waddr = addr1[MEM_AW-1:0];
				mem_wdata = replace_q ? spill_q : (rdata_q | spill_q);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.wr_sel == WR_CLR) begin
				clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			end
			if (cmd.load && req.operation == OP_WRITE) begin
				row_cnt_q <= req.last_row ? '0 : row_cnt_q + ROW_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req.operation;
			replace_q <= req.replace_mode;
			addr0_q   <= addr_calc;
			head_q    <= req.row_bits >> req.pos_x[SHIFT_W-1:0];
			spill_q   <= spill_wide[WORD_W-1:0];
			raddr_q   <= req.read_address;
		end
		if (cmd.load_rsp) begin
			if (op_q == OP_READ) begin
				rsp_q.read_word <= rd_ok ? rdata_q : '0;
				rsp_q.dropped   <= 1'b0;
			end else begin
				rsp_q.read_word <= '0;
				rsp_q.dropped   <= !(ok0 && ok1);
			end
		end
	end

	`SBRB_ASSERT_NOW(a_write_in_range, mem_we, {1'b0, mem_waddr} < MEM_LIMIT_W, "write beyond framebuffer")
	`SBRB_ASSERT_NOW(a_no_rw_collision, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one word")
	`SBRB_ASSERT_NOW(a_clear_only_zero, cmd.wr_sel == WR_CLR, mem_wdata == '0, "clear writes nonzero data")

endmodule

// File: rtl/shifted_bitmap_row_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted bitmap row blitter
// Places 16-pixel bitmap rows into a one-bit-per-pixel word framebuffer,
// ORed or replaced, and reads framebuffer words back.
// ----------------------------------------------------------------------------
// After reset the block zeroes all LINE_WORDS*SCREEN_LINES framebuffer words
// (16000 with the defaults), one word per cycle; req_ready stays low until
// that pass ends. A write request then passes through the states RD0, RD1, WR1
// and FIN before its response is loaded into the response register, and a
// read request through RDR and FIN; req_ready rises again with that load, so
// requests are taken one at a time. The load into the response register
// waits while an earlier response still sits there unaccepted. The write
// sequence is set by the framebuffer memory, which has one write and one read
// port, so the two word updates of a row run as read, merged write with second
// read, and second write. A new request is taken while the last response still
// waits on rsp_ready.

module shifted_bitmap_row_blitter
	import sbrb_pkg::*;
#(
	parameter int LINE_WORDS   = LINE_WORDS_DEF,
	parameter int SCREEN_LINES = SCREEN_LINES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  blit_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output blit_rsp_t rsp
);

	sbrb_cmd_t cmd;
	sbrb_sts_t sts;

	sbrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbrb_dpath #(
		.LINE_WORDS   (LINE_WORDS),
		.SCREEN_LINES (SCREEN_LINES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: verif/sbrb_frame_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap row blitter response checker
// Watches the request and response channels and keeps a shadow framebuffer and
// row counter. Each accepted request yields its expected response. Each
// accepted response is compared with the oldest expected response, one field
// at a time.
// ----------------------------------------------------------------------------
module sbrb_frame_check
	import sbrb_pkg::*;
#(
	parameter int LINE_WORDS   = LINE_WORDS_DEF,
	parameter int SCREEN_LINES = SCREEN_LINES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  blit_req_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  blit_rsp_t rsp,
	output int        errors,
	output int        outstanding,
	output int        rows_drawn,
	output int        rows_dropped,
	output int        reads_done
);

	localparam int FB_WORDS = LINE_WORDS * SCREEN_LINES;

	logic [WORD_W-1:0]    fb_words [FB_WORDS];
	logic [ROW_CNT_W-1:0] row_line;
	blit_rsp_t            rsp_due_q [$];

	function automatic logic merge_word(int addr, logic [WORD_W-1:0] bits, logic repl);
		if (addr >= FB_WORDS)
			return 1'b0;
		fb_words[addr] = repl ? bits : (fb_words[addr] | bits);
		return 1'b1;
	endfunction

	function automatic blit_rsp_t blit_or_read(blit_req_t r);
		blit_rsp_t           p;
		int                  addr;
		logic [2*WORD_W-1:0] placed;
		logic                head_ok;
		logic                spill_ok;
		p = '0;
		if (r.operation == OP_READ) begin
			if (int'(r.read_address) < FB_WORDS)
				p.read_word = fb_words[r.read_address];
			reads_done++;
			return p;
		end
		addr = (int'(r.pos_y) + int'(row_line)) * LINE_WORDS + int'(r.pos_x >> 4);
		placed = {r.row_bits, {WORD_W{1'b0}}} >> r.pos_x[SHIFT_W-1:0];
		head_ok = merge_word(addr, placed[2*WORD_W-1:WORD_W], r.replace_mode);
		spill_ok = merge_word(addr + 1, placed[WORD_W-1:0], r.replace_mode);
		p.dropped = !(head_ok && spill_ok);
		row_line = r.last_row ? '0 : row_line + 1'b1;
		rows_drawn++;
		if (p.dropped)
			rows_dropped++;
		return p;
	endfunction

	always @(posedge clk) begin
		blit_rsp_t want;
		if (!arst_n) begin
			foreach (fb_words[i])
				fb_words[i] = '0;
			row_line = '0;
			rsp_due_q.delete();
			errors = 0;
			rows_drawn = 0;
			rows_dropped = 0;
			reads_done = 0;
			outstanding <= 0;
		end else begin
			// check the response before the request so that a same-edge request is not matched
			if (rsp_valid && rsp_ready) begin
				if (rsp_due_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected response, got read_word %h dropped %b",
						$time, rsp.read_word, rsp.dropped);
				end else begin
					want = rsp_due_q.pop_front();
					if (rsp.read_word !== want.read_word) begin
						errors++;
						$display("%0t: read_word mismatch, expected %h got %h",
							$time, want.read_word, rsp.read_word);
					end
					if (rsp.dropped !== want.dropped) begin
						errors++;
						$display("%0t: dropped mismatch, expected %b got %b",
							$time, want.dropped, rsp.dropped);
					end
				end
			end
			if (req_valid && req_ready)
				rsp_due_q.push_back(blit_or_read(req));
			outstanding <= rsp_due_q.size();
		end
	end

endmodule

// File: verif/tb_shifted_bitmap_row_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap row blitter testbench
// Drives directed and random bitmap row writes and framebuffer reads under
// several sender and receiver pacing phases. The test includes a long receiver
// hold-off and a full row counter wrap. A separate checker predicts and
// compares the responses. This top module gives the verdict.
// ----------------------------------------------------------------------------
module tb_shifted_bitmap_row_blitter;
	import sbrb_pkg::*;

	localparam int LINE_WORDS   = LINE_WORDS_DEF;
	localparam int SCREEN_LINES = SCREEN_LINES_DEF;
	localparam int FB_WORDS     = LINE_WORDS * SCREEN_LINES;
	localparam int PHASE_ITEMS  = 170;
	localparam int HOLD_CYCLES  = 400;
	localparam int WRAP_ROWS    = 520;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	blit_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	blit_rsp_t rsp;

	int   req_idle_pct = 0;
	int   rsp_stall_pct = 0;
	logic hold_start = 1'b0;
	int   hold_left = 0;
	int   items_sent = 0;

	int errors;
	int outstanding;
	int rows_drawn;
	int rows_dropped;
	int reads_done;

	shifted_bitmap_row_blitter #(
		.LINE_WORDS  (LINE_WORDS),
		.SCREEN_LINES(SCREEN_LINES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	sbrb_frame_check #(
		.LINE_WORDS  (LINE_WORDS),
		.SCREEN_LINES(SCREEN_LINES)
	) frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.rows_drawn  (rows_drawn),
		.rows_dropped(rows_dropped),
		.reads_done  (reads_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic blit_req_t noise_req();
		blit_req_t   r;
		logic [31:0] a;
		logic [31:0] b;
		a = $urandom;
		b = $urandom;
		r.operation = a[0];
		r.replace_mode = a[1];
		r.last_row = a[2];
		r.pos_x = a[12:3];
		r.pos_y = a[21:13];
		r.row_bits = b[15:0];
		r.read_address = b[29:16];
		return r;
	endfunction

	function automatic blit_req_t row_req(int x, int y, logic [WORD_W-1:0] bits, logic repl,
		logic last);
		blit_req_t r;
		r = noise_req();
		r.operation = OP_WRITE;
		r.replace_mode = repl;
		r.pos_x = POS_X_W'(x);
		r.pos_y = POS_Y_W'(y);
		r.row_bits = bits;
		r.last_row = last;
		return r;
	endfunction

	function automatic blit_req_t read_req(int addr);
		blit_req_t r;
		r = noise_req();
		r.operation = OP_READ;
		r.read_address = RADDR_W'(addr);
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pick_row();
		return ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
	endfunction

	task automatic push_request(input blit_req_t r);
		if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < req_idle_pct);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_traffic();
		int   pick;
		int   x;
		int   y;
		int   rows;
		int   line;
		logic repl;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 639);
			y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 399);
			rows = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
			repl = 1'($urandom_range(0, 1));
			for (int i = 0; i < rows; i++)
				push_request(row_req(x, y, pick_row(), repl, i == rows - 1));
			repeat ($urandom_range(1, 3)) begin
				line = y + $urandom_range(0, rows - 1);
				push_request(read_req(line * LINE_WORDS + x / 16 + $urandom_range(0, 1)));
			end
		end else if (pick < 85) begin
			if ($urandom_range(0, 9) == 0)
				push_request(read_req($urandom_range(0, 16383)));
			else
				push_request(read_req($urandom_range(0, FB_WORDS - 1)));
		end else begin
			push_request(noise_req());
		end
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int n);
		int stop_at;
		req_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		stop_at = items_sent + n;
		while (items_sent < stop_at)
			random_traffic();
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// aligned and shifted rows, row counter advance and clear
		push_request(row_req(0, 0, 16'hFFFF, 1'b0, 1'b0));
		push_request(row_req(5, 0, 16'h8001, 1'b1, 1'b1));
		push_request(read_req(0));
		push_request(read_req(LINE_WORDS));
		push_request(read_req(LINE_WORDS + 1));
		// spill wraps into the next line
		push_request(row_req(639, 10, 16'hFFFF, 1'b0, 1'b1));
		push_request(read_req(10 * LINE_WORDS + 39));
		push_request(read_req(11 * LINE_WORDS));
		// spill past the end of memory, then both words out of range
		push_request(row_req(639, 399, 16'hA5A5, 1'b0, 1'b1));
		push_request(read_req(FB_WORDS - 1));
		push_request(row_req(1023, 511, 16'hFFFF, 1'b1, 1'b0));
		push_request(row_req(16, 0, 16'h1234, 1'b0, 1'b1));
		// replace on an aligned column clears the spill word
		push_request(row_req(32, 0, 16'hFFFF, 1'b0, 1'b1));
		push_request(row_req(40, 0, 16'hFFFF, 1'b0, 1'b1));
		push_request(row_req(32, 0, 16'h0F0F, 1'b1, 1'b1));
		push_request(row_req(48, 0, 16'h0000, 1'b1, 1'b1));
		push_request(read_req(2));
		push_request(read_req(3));
		push_request(read_req(4));
		// reads out of range
		push_request(read_req(FB_WORDS));
		push_request(read_req(16383));
		wait_idle();

		// drive the row counter through its wrap
		for (int i = 0; i < WRAP_ROWS; i++)
			push_request(row_req(200, 0, pick_row(), 1'b0, i == WRAP_ROWS - 1));
		push_request(read_req(12));
		push_request(read_req(13));
		push_request(read_req(7 * LINE_WORDS + 12));
		push_request(read_req(8 * LINE_WORDS + 13));
		wait_idle();

		// hold responses off while requests keep coming, then drain
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		repeat (40)
			random_traffic();
		wait_idle();

		run_phase(0, 0, PHASE_ITEMS);
		run_phase(54, 0, PHASE_ITEMS);
		run_phase(0, 54, PHASE_ITEMS);
		run_phase(8, 8, PHASE_ITEMS);

		repeat (10) @(posedge clk);
		$display("run covered %0d requests: %0d bitmap rows (%0d with a dropped word), %0d reads",
			items_sent, rows_drawn, rows_dropped, reads_done);
		$display("pacing: free flow, sender gaps, receiver stalls, mixed, long receiver hold-off");
		if (errors == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/sbrb_pkg.sv
rtl/sbrb_ctrl.sv
rtl/sbrb_dpath.sv
rtl/shifted_bitmap_row_blitter.sv
verif/sbrb_frame_check.sv
verif/tb_shifted_bitmap_row_blitter.sv
